// ----- rtl/core/rbd_pkg.sv -----
// Shared types and constants for the reversible bounded deque.
package rbd_pkg;

  // Request codes carried on in_req_type.
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_DUMP       = 3'd4,
    REQ_REVERSE    = 3'd5
  } req_t;

  // Result status codes carried on out_status.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_EMPTY = 2'd3
  } stat_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // Upper bound on the entries one dump emits.
  localparam int unsigned MAX_DUMP = 32;
  // Width of the dump counter; covers every supported capacity and MAX_DUMP.
  localparam int unsigned CNT_W = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  push_low;
    logic  push_high;
    logic  pop_low;
    logic  pop_high;
    logic  flip;
    logic  dump_rd;
    logic  cnt_clr;
    logic  emit;
    stat_t status;
    logic  last;
    logic  sel_mem;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic rev;
    logic dump_last;
  } dp_stat_t;

endpackage

// ----- rtl/core/rbd_ctrl.sv -----
// Controller state machine: decodes requests and sequences dumps.
module rbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        req_type,
  input  rbd_pkg::dp_stat_t stat,
  output logic              busy,
  output rbd_pkg::cmd_t     cmd
);

  rbd_pkg::state_t state_r, state_nxt;
  rbd_pkg::req_t   req;
  logic            accept;

  assign req    = rbd_pkg::req_t'(req_type);
  assign accept = start && (state_r == rbd_pkg::S_IDLE);
  assign busy   = (state_r == rbd_pkg::S_DUMP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rbd_pkg::S_IDLE: begin
        if (accept && req == rbd_pkg::REQ_DUMP && !stat.empty && !stat.dump_last) begin
          state_nxt = rbd_pkg::S_DUMP;
        end
      end
      rbd_pkg::S_DUMP: begin
        if (stat.dump_last) begin
          state_nxt = rbd_pkg::S_IDLE;
        end
      end
      default: state_nxt = rbd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = rbd_pkg::ST_OK;
    unique case (state_r)
      rbd_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req)
            rbd_pkg::REQ_PUSH_FRONT, rbd_pkg::REQ_PUSH_BACK: begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              if (stat.full) begin
                cmd.status = rbd_pkg::ST_OVER;
              end else if ((req == rbd_pkg::REQ_PUSH_FRONT) != stat.rev) begin
                cmd.push_low = 1'b1;
              end else begin
                cmd.push_high = 1'b1;
              end
            end
            rbd_pkg::REQ_POP_FRONT, rbd_pkg::REQ_POP_BACK: begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              if (stat.empty) begin
                cmd.status = rbd_pkg::ST_UNDER;
              end else begin
                cmd.sel_mem = 1'b1;
                if ((req == rbd_pkg::REQ_POP_FRONT) != stat.rev) begin
                  cmd.pop_low = 1'b1;
                end else begin
                  cmd.pop_high = 1'b1;
                end
              end
            end
            rbd_pkg::REQ_DUMP: begin
              cmd.emit = 1'b1;
              if (stat.empty) begin
                cmd.status = rbd_pkg::ST_EMPTY;
                cmd.last   = 1'b1;
              end else begin
                cmd.dump_rd = 1'b1;
                cmd.sel_mem = 1'b1;
                cmd.last    = stat.dump_last;
                cmd.cnt_clr = stat.dump_last;
              end
            end
            rbd_pkg::REQ_REVERSE: begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              if (stat.empty) begin
                cmd.status = rbd_pkg::ST_EMPTY;
              end else begin
                cmd.flip = 1'b1;
              end
            end
            default: begin
              // Undefined request codes are dropped without a result.
              cmd.emit = 1'b0;
            end
          endcase
        end
      end
      rbd_pkg::S_DUMP: begin
        cmd.emit    = 1'b1;
        cmd.dump_rd = 1'b1;
        cmd.sel_mem = 1'b1;
        cmd.last    = stat.dump_last;
        cmd.cnt_clr = stat.dump_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/core/rbd_dp.sv -----
// Datapath: ring buffer storage, head and occupancy, orientation and result registers.
module rbd_dp #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rbd_pkg::cmd_t      cmd,
  input  logic signed [31:0] value,
  output rbd_pkg::dp_stat_t  stat,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic               out_last
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
  localparam int unsigned CNT_W = rbd_pkg::CNT_W;

  logic [31:0]      mem [CAPACITY];
  logic [IDX_W-1:0] head_r;
  logic [OCC_W-1:0] occ_r;
  logic             rev_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      rd_data_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic             out_last_r;
  logic             out_sel_r;

  logic [IDX_W-1:0] head_dec, head_inc;
  logic [IDX_W-1:0] occ_idx, occ_m1_idx, cnt_idx, dump_off;
  logic [IDX_W-1:0] waddr, raddr;
  logic [CNT_W-1:0] occ_ext, dump_n;
  logic             we, re;

  // Wraps head + offset into the ring; both operands are below CAPACITY.
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign occ_ext    = CNT_W'(occ_r);
  assign dump_n     = (occ_ext < CNT_W'(rbd_pkg::MAX_DUMP)) ? occ_ext
                                                            : CNT_W'(rbd_pkg::MAX_DUMP);
  assign occ_idx    = occ_r[IDX_W-1:0];
  assign occ_m1_idx = occ_idx - 1'b1;
  assign cnt_idx    = cnt_r[IDX_W-1:0];
  assign dump_off   = rev_r ? (occ_m1_idx - cnt_idx) : cnt_idx;

  assign head_dec = (head_r == '0) ? IDX_W'(CAPACITY - 1) : head_r - 1'b1;
  assign head_inc = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + 1'b1;

  assign we    = cmd.push_low || cmd.push_high;
  assign waddr = cmd.push_low ? head_dec : slot(head_r, occ_idx);
  assign re    = cmd.pop_low || cmd.pop_high || cmd.dump_rd;

  always_comb begin
    if (cmd.pop_low) begin
      raddr = head_r;
    end else if (cmd.pop_high) begin
      raddr = slot(head_r, occ_m1_idx);
    end else begin
      raddr = slot(head_r, dump_off);
    end
  end

  assign stat.full      = (occ_r == OCC_W'(CAPACITY));
  assign stat.empty     = (occ_r == '0);
  assign stat.rev       = rev_r;
  assign stat.dump_last = ((cnt_r + 1'b1) == dump_n);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= value;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      occ_r       <= '0;
      rev_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.push_low) begin
        head_r <= head_dec;
      end else if (cmd.pop_low) begin
        head_r <= head_inc;
      end
      if (we) begin
        occ_r <= occ_r + 1'b1;
      end else if (cmd.pop_low || cmd.pop_high) begin
        occ_r <= occ_r - 1'b1;
      end
      if (cmd.flip) begin
        rev_r <= ~rev_r;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.dump_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= cmd.status;
    out_last_r   <= cmd.last;
    out_sel_r    <= cmd.sel_mem;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;
  assign out_data   = (out_valid_r && out_sel_r) ? $signed(rd_data_r) : 32'sd0;

endmodule

// ----- rtl/core/reversible_bounded_deque.sv -----
// Top level of the reversible bounded deque of signed 32-bit words.
//
// A request is taken at a rising edge where start is high and busy is low, and
// its results appear on the out_ ports starting in the next cycle, one per cycle,
// each marked by out_valid for exactly one cycle; the receiver cannot stall them,
// so it must take every result in the cycle it is shown. Push, pop and reverse
// produce one result each and never raise busy, so such requests may follow each
// other in every cycle. A dump of n stored words produces min(n, 32) results in
// consecutive cycles and holds busy high after the request is taken until the
// last entry is read, because the storage has a single read port that delivers one
// entry per cycle. The storage is a ring buffer with a head index and an
// occupancy count; reverse only toggles an orientation flag that swaps which
// physical end is the logical front. Pushing into a full queue reports overflow
// and stores nothing, popping an empty queue reports underflow, and a dump or
// reverse of an empty queue reports empty. Request codes six and seven are
// dropped without a result. Stored words need no reset; only control state is
// cleared, so no clearing pass follows reset.
module reversible_bounded_deque #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic               out_last
);

  // Commands from the controller and status back from the datapath.
  rbd_pkg::cmd_t     cmd;
  rbd_pkg::dp_stat_t stat;

  // The controller decodes each request against the full, empty and
  // orientation status and walks the dump one entry per cycle.
  rbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  // The datapath owns the ring storage, its pointers and the result registers.
  rbd_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .value      (in_value),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last)
  );

endmodule
